/* src/bbe_pkg.sv */
// ----------------------------------------------------------------------------
// bbe_pkg: shared types and constants of the 3x3 box blur
// Frame limits, word layouts of both channels, register indexes and the
// reciprocal table used to divide a window sum by its pixel count.
// ----------------------------------------------------------------------------
`default_nettype none

package bbe_pkg;

  // frame limits and derived widths
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int RowW      = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int WLenW     = $clog2(MaxWidth + 1);
  localparam int HLenW     = $clog2(MaxHeight + 1);
  // item counter only needs to reach width + 2
  localparam int SeenCap   = MaxWidth + 2;
  localparam int SeenW     = $clog2(SeenCap + 1);

  // configuration registers
  localparam int                  DimW           = 11;
  localparam logic [DimW-1:0]     DimReset       = 11'd1024;
  localparam int                  CfgAddrW       = 1;
  localparam logic [CfgAddrW-1:0] RegImageWidth  = 1'b0;
  localparam logic [CfgAddrW-1:0] RegImageHeight = 1'b1;

  // mean arithmetic
  localparam int SumW       = 12;  // nine 8-bit values
  localparam int CntW       = 4;   // up to nine pixels
  localparam int NumW       = 13;  // 2 * sum + count
  localparam int RecipW     = 18;
  localparam int RecipShift = 18;
  localparam int ProdW      = NumW + RecipW;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // entry 3*r + c is row r, column c of the window, column 2 newest
  typedef rgb_t [8:0] window_t;

  typedef struct packed {
    logic [2:0] row_ok;
    logic [2:0] col_ok;
  } win_mask_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       out_last;
  } out_word_t;

  // ceil(2^RecipShift / (2 * cnt)); exact floor division for numerators below 4600
  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] r;
    case (cnt)
      4'd1:    r = RecipW'(131072);
      4'd2:    r = RecipW'(65536);
      4'd3:    r = RecipW'(43691);
      4'd4:    r = RecipW'(32768);
      4'd5:    r = RecipW'(26215);
      4'd6:    r = RecipW'(21846);
      4'd7:    r = RecipW'(18725);
      4'd8:    r = RecipW'(16384);
      4'd9:    r = RecipW'(14564);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/box_blur_3x3_edge_aware_unit.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_unit: streaming 3x3 box blur over RGB frames
// Two line-store memories feed a 3x3 window; each pixel becomes the rounded
// mean of its in-frame neighbors.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on in_valid/in_stall/in_word in raster order; blurred pixels
// leave on out_valid/out_stall/out_word. Every accepted word after the first
// image_width+1 of a frame gives one output word; after the last frame pixel
// send image_width+1 drain words (req_type = 1) to flush the frame. out_last
// marks the final pixel, after which the next word starts a new frame.
// A drain word while frame pixels are still due is taken and discarded.
// Per word: line-store read at accept, window shift and write-back, and for
// a word with output the window sum and the reciprocal multiply into the
// output register; a discarded drain stops at acceptance. The next word is
// taken while an output waits; a held output blocks the multiply stage and
// with it the input. image_width and image_height are written through
// cfg_wr_en/cfg_addr/cfg_wdata; the user must write them only while idle;
// the block does not enforce this. Reset (rst, synchronous) restores both to
// 1024, clears all counters and the window, and keeps line-store contents.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_edge_aware_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bbe_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [bbe_pkg::DimW-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bbe_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bbe_pkg::out_word_t            out_word
);

  import bbe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_MUL  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [DimW-1:0]  image_width, image_height;
  logic [WLenW-1:0] w;
  logic [HLenW-1:0] h;

  logic [ColW-1:0]  input_column;
  logic [HLenW-1:0] input_row;
  logic [ColW-1:0]  output_column;
  logic [RowW-1:0]  output_row;
  logic [SeenW-1:0] items_seen;

  rgb_t upper_mem  [MaxWidth];
  rgb_t middle_mem [MaxWidth];
  rgb_t upper_q, middle_q, bot_pix;
  logic [ColW-1:0] rd_addr;

  window_t   window, window_next;
  win_mask_t mask, mask_next;
  logic      last_flag;
  rgb_t      mean;

  logic accept, frame_in, drop, start, rmw, out_load;
  logic col_wrap, ocol_wrap, emit, last_next;
  logic [SeenW-1:0] seen_inc;
  logic [HLenW:0]   orow_inc;
  logic [HLenW:0]   row_pos [3];
  logic [WLenW:0]   col_pos [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DimReset;
      image_height <= DimReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        RegImageWidth:  image_width  <= cfg_wdata;
        RegImageHeight: image_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp frame size to 1..max
  always_comb begin
    if (image_width == '0) begin
      w = WLenW'(1);
    end else if (int'(image_width) > MaxWidth) begin
      w = WLenW'(MaxWidth);
    end else begin
      w = WLenW'(image_width);
    end
    if (image_height == '0) begin
      h = HLenW'(1);
    end else if (int'(image_height) > MaxHeight) begin
      h = HLenW'(MaxHeight);
    end else begin
      h = HLenW'(image_height);
    end
  end

  // input handshake
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign frame_in = (input_row < h);
  assign drop     = in_word.req_type && frame_in;
  assign start    = accept && !drop;
  assign rmw      = (state == ST_READ);
  assign out_load = (state == ST_MUL) && (!out_valid || !out_stall);

  // line stores: read at accept, write back during the window update
  always_ff @(posedge clk) begin
    if (start) begin
      upper_q <= upper_mem[input_column];
    end
    if (rmw) begin
      upper_mem[rd_addr] <= middle_q;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      middle_q <= middle_mem[input_column];
    end
    if (rmw) begin
      middle_mem[rd_addr] <= bot_pix;
    end
  end

  // latch address and bottom pixel of the accepted word
  always_ff @(posedge clk) begin
    if (start) begin
      rd_addr <= input_column;
      if (frame_in) begin
        bot_pix <= {in_word.in_red, in_word.in_green, in_word.in_blue};
      end else begin
        bot_pix <= '0;
      end
    end
  end

  // window shift
  always_comb begin
    window_next = window;
    for (int r = 0; r < 3; r++) begin
      window_next[r*3]   = window[r*3+1];
      window_next[r*3+1] = window[r*3+2];
    end
    window_next[2] = upper_q;
    window_next[5] = middle_q;
    window_next[8] = bot_pix;
  end

  // in-frame mask of the output neighborhood (positions are frame index + 1)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_pos[k]       = (HLenW+1)'(output_row) + (HLenW+1)'(k);
      col_pos[k]       = (WLenW+1)'(output_column) + (WLenW+1)'(k);
      mask_next.row_ok[k] = (row_pos[k] != '0) && (row_pos[k] <= (HLenW+1)'(h));
      mask_next.col_ok[k] = (col_pos[k] != '0) && (col_pos[k] <= (WLenW+1)'(w));
    end
  end

  // counter steps
  always_comb begin
    col_wrap  = ((WLenW+1)'(input_column) + (WLenW+1)'(1)) >= (WLenW+1)'(w);
    seen_inc  = (items_seen == SeenW'(SeenCap)) ? items_seen : items_seen + SeenW'(1);
    emit      = seen_inc >= (SeenW'(w) + SeenW'(2));
    ocol_wrap = ((WLenW+1)'(output_column) + (WLenW+1)'(1)) >= (WLenW+1)'(w);
    orow_inc  = (HLenW+1)'(output_row) + (HLenW+1)'(1);
    last_next = emit && ocol_wrap && (orow_inc >= (HLenW+1)'(h));
  end

  // window, counters and mask update
  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      input_column  <= '0;
      input_row     <= '0;
      output_column <= '0;
      output_row    <= '0;
      items_seen    <= '0;
    end else if (rmw) begin
      window <= window_next;
      mask   <= mask_next;
      last_flag <= last_next;
      if (last_next) begin
        input_column  <= '0;
        input_row     <= '0;
        output_column <= '0;
        output_row    <= '0;
        items_seen    <= '0;
      end else begin
        items_seen <= seen_inc;
        if (col_wrap) begin
          input_column <= '0;
          if (input_row < HLenW'(MaxHeight)) begin
            input_row <= input_row + HLenW'(1);
          end
        end else begin
          input_column <= input_column + ColW'(1);
        end
        if (emit) begin
          if (ocol_wrap) begin
            output_column <= '0;
            output_row    <= RowW'(orow_inc);
          end else begin
            output_column <= output_column + ColW'(1);
          end
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = emit ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // mean datapath
  bbe_mean u_mean (
    .clk    (clk),
    .load   (state == ST_SUM),
    .window (window),
    .mask   (mask),
    .mean   (mean)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word.out_red   <= mean.red;
      out_word.out_green <= mean.green;
      out_word.out_blue  <= mean.blue;
      out_word.out_last  <= last_flag;
    end
  end

endmodule

`default_nettype wire

/* src/bbe_mean.sv */
// ----------------------------------------------------------------------------
// bbe_mean: masked window sum and rounded mean
// Sums each channel over the in-frame window pixels into registers, then
// divides (2*sum + count) by 2*count with a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_mean (
  input  logic              clk,
  input  logic              load,
  input  bbe_pkg::window_t  window,
  input  bbe_pkg::win_mask_t mask,
  output bbe_pkg::rgb_t     mean
);

  import bbe_pkg::*;

  logic [SumW-1:0]  red_sum_next, green_sum_next, blue_sum_next;
  logic [CntW-1:0]  cnt_next;
  logic [SumW-1:0]  red_sum, green_sum, blue_sum;
  logic [CntW-1:0]  cnt;
  logic [RecipW-1:0] rcp;
  logic [NumW-1:0]  red_num, green_num, blue_num;
  logic [ProdW-1:0] red_prod, green_prod, blue_prod;

  // masked sums over the nine window taps
  always_comb begin
    red_sum_next   = '0;
    green_sum_next = '0;
    blue_sum_next  = '0;
    cnt_next       = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (mask.row_ok[r] && mask.col_ok[c]) begin
          red_sum_next   = red_sum_next   + SumW'(window[r*3+c].red);
          green_sum_next = green_sum_next + SumW'(window[r*3+c].green);
          blue_sum_next  = blue_sum_next  + SumW'(window[r*3+c].blue);
          cnt_next       = cnt_next + CntW'(1);
        end
      end
    end
  end

  // sum stage registers
  always_ff @(posedge clk) begin
    if (load) begin
      red_sum   <= red_sum_next;
      green_sum <= green_sum_next;
      blue_sum  <= blue_sum_next;
      cnt       <= cnt_next;
    end
  end

  // rounded division; zero count gives zero through a zero reciprocal
  always_comb begin
    rcp        = recip(cnt);
    red_num    = {red_sum, 1'b0} + NumW'(cnt);
    green_num  = {green_sum, 1'b0} + NumW'(cnt);
    blue_num   = {blue_sum, 1'b0} + NumW'(cnt);
    red_prod   = ProdW'(red_num) * ProdW'(rcp);
    green_prod = ProdW'(green_num) * ProdW'(rcp);
    blue_prod  = ProdW'(blue_num) * ProdW'(rcp);
    mean.red   = red_prod[RecipShift +: 8];
    mean.green = green_prod[RecipShift +: 8];
    mean.blue  = blue_prod[RecipShift +: 8];
  end

endmodule

`default_nettype wire

/* src/bbe_checker.sv */
// ----------------------------------------------------------------------------
// bbe_checker: port-level checks of the box blur
// Watches reset, output timing relative to input words, and output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bbe_pkg::out_word_t out_word
);

  import bbe_pkg::*;

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // a new output follows its taken word through the read, sum and multiply states
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 4))
    else $error("output without a word taken four cycles before");

  // producing an output returns the block to ready
  a_ready_after_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("input stalled as output appears");

  // a held output word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output changed");

endmodule

bind box_blur_3x3_edge_aware_unit bbe_checker u_bbe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
